// ===== design/hcsg_pkg.sv =====
package hcsg_pkg;

  typedef enum logic [1:0] {
    KIND_CLEAR = 2'd0,
    KIND_SPLAT = 2'd1,
    KIND_READ  = 2'd2,
    KIND_NOP   = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    CFG_CELL_SIZE = 2'd0,
    CFG_DECAY     = 2'd1,
    CFG_COLS      = 2'd2,
    CFG_ROWS      = 2'd3
  } cfg_index_e;

  localparam int unsigned POS_W     = 12;
  localparam int unsigned AMT_W     = 9;
  localparam int unsigned IDX_W     = 9;
  localparam int unsigned D2_W      = 17;
  localparam int unsigned SQ_T_W    = 36;
  localparam int unsigned ROOT_W    = 18;
  localparam int unsigned M_W       = 19;
  localparam int unsigned DIV_STEPS = 12;
  localparam int unsigned SQ_STEPS  = 18;
  localparam int unsigned K_STEPS   = 19;

  localparam logic [7:0] COLOR_FULL = 8'd255;
  localparam logic [7:0] GREEN_KNEE = 8'd204;

endpackage

// ===== design/heatmap_cone_splat_grid.sv =====
// A clear item sweeps every cell of the next-level store, and a read item looks
// up one cell. A splat outside the grid or with no radius ends after the divide
// steps; a splat with a radius visits each cell of its bounding box and runs the
// square-root and divide steps only for the cells that lie inside the disk.
// One item is worked on at a time. After reset a clearing pass over all
// GRID_COLS*GRID_ROWS cells zeroes both stores before the first item is taken.
module heatmap_cone_splat_grid #(
  parameter int unsigned GRID_COLS  = 64,
  parameter int unsigned GRID_ROWS  = 64,
  parameter int unsigned LEVEL_BITS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_index_i,
  input  logic [8:0]         cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [1:0]         kind_i,
  input  logic signed [11:0] x_pos_i,
  input  logic signed [11:0] y_pos_i,
  input  logic [8:0]         amount_i,
  input  logic [5:0]         cell_col_i,
  input  logic [5:0]         cell_row_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [15:0]        level_o,
  output logic [7:0]         red_o,
  output logic [7:0]         green_o,
  output logic [7:0]         blue_o,
  output logic               changed_o,
  output logic               accepted_o
);

  localparam int unsigned CELLS  = GRID_COLS * GRID_ROWS;
  localparam int unsigned ADDR_W = (CELLS > 1) ? $clog2(CELLS) : 1;
  localparam int unsigned IW     = hcsg_pkg::IDX_W;
  localparam logic [IW-1:0] NCOL_MAX = IW'(GRID_COLS);
  localparam logic [IW-1:0] NROW_MAX = IW'(GRID_ROWS);
  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(CELLS - 1);
  localparam logic [LEVEL_BITS-1:0] LEVEL_MAX = {LEVEL_BITS{1'b1}};
  localparam int unsigned GREEN_KNEE_L = 204;

  typedef enum logic [14:0] {
    ST_INIT  = 15'b000000000000001,
    ST_IDLE  = 15'b000000000000010,
    ST_CLEAR = 15'b000000000000100,
    ST_DIV   = 15'b000000000001000,
    ST_CHECK = 15'b000000000010000,
    ST_PREP  = 15'b000000000100000,
    ST_D2    = 15'b000000001000000,
    ST_GATE  = 15'b000000010000000,
    ST_SQRT  = 15'b000000100000000,
    ST_KDIV  = 15'b000001000000000,
    ST_RD    = 15'b000010000000000,
    ST_NEXT  = 15'b000100000000000,
    ST_RADDR = 15'b001000000000000,
    ST_RWAIT = 15'b010000000000000,
    ST_DONE  = 15'b100000000000000
  } state_e;

  state_e state_q, state_d;

  logic [4:0] cell_size_q;
  logic [8:0] decay_q;
  logic [6:0] cols_q, rows_q;

  logic [8:0]  amount_q;
  logic        xneg_q, yneg_q;
  logic [5:0]  col_q, row_q;
  logic [4:0]  cnt_q;
  logic [ADDR_W-1:0] sweep_q;

  logic [11:0] nx_q, ny_q, na_q, qx_q, qy_q, qa_q;
  logic [4:0]  rx_q, ry_q;
  logic [8:0]  ra_q;

  logic [IW-1:0] cx_q, cy_q, x0_q, x1_q, y0_q, y1_q, i_q, j_q;
  logic [8:0]  r_q;
  logic [17:0] a2_q, r2_q;
  logic [hcsg_pkg::D2_W-1:0] d2_q;
  logic [hcsg_pkg::SQ_T_W-1:0] sq_t_q;
  logic [19:0] sq_rem_q;
  logic [hcsg_pkg::ROOT_W-1:0] sq_root_q;
  logic [hcsg_pkg::M_W-1:0] kn_q, kq_q;
  logic [8:0]  kr_q;
  logic [8:0]  add_q;

  logic [15:0] res_level_q;
  logic [7:0]  res_red_q, res_green_q, res_blue_q;
  logic        res_changed_q, res_acc_q;

  logic        out_valid_q;
  logic [15:0] out_level_q;
  logic [7:0]  out_red_q, out_green_q, out_blue_q;
  logic        out_changed_q, out_acc_q;

  logic [4:0] cs_eff;
  logic [8:0] dc_eff;
  logic [IW-1:0] nc, nr;
  logic in_fire, out_fire, out_load;

  logic [ADDR_W-1:0] mem_addr;
  logic next_we, shown_we;
  logic [LEVEL_BITS-1:0] next_wdata, shown_wdata, next_rdata, shown_rdata;
  logic [LEVEL_BITS:0] sat_sum;

  logic [5:0]  trial_x, trial_y;
  logic [9:0]  trial_a;
  logic        ge_x, ge_y, ge_a;
  logic [21:0] sq_rem_w, sq_trial;
  logic        sq_ge;
  logic [9:0]  k_trial;
  logic        k_ge;
  logic [hcsg_pkg::M_W-1:0] k_ceil;
  logic [8:0]  k_clamp;
  logic        in_x, in_y;
  logic [9:0]  hi_x, hi_y;
  logic [9:0]  di, dj;
  logic [8:0]  di_abs, dj_abs;
  logic [LEVEL_BITS-1:0] excess;

  function automatic logic [ADDR_W-1:0] cell_addr(input logic [IW-1:0] c,
                                                  input logic [IW-1:0] r);
    logic [ADDR_W+IW-1:0] full;
    full = (ADDR_W+IW)'(c) * (ADDR_W+IW)'(GRID_ROWS) + (ADDR_W+IW)'(r);
    return full[ADDR_W-1:0];
  endfunction

  assign cs_eff = (cell_size_q == 5'd0) ? 5'd1 : cell_size_q;
  assign dc_eff = (decay_q == 9'd0) ? 9'd1 : decay_q;
  assign nc = (IW'(cols_q) > NCOL_MAX) ? NCOL_MAX : IW'(cols_q);
  assign nr = (IW'(rows_q) > NROW_MAX) ? NROW_MAX : IW'(rows_q);

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_fire    = in_valid_i && !in_stall_o;
  assign out_fire   = out_valid_q && !out_stall_i;
  assign out_load   = (state_q == ST_DONE) && (!out_valid_q || !out_stall_i);

  assign trial_x = {rx_q, nx_q[11]};
  assign trial_y = {ry_q, ny_q[11]};
  assign trial_a = {ra_q, na_q[11]};
  assign ge_x = trial_x >= {1'b0, cs_eff};
  assign ge_y = trial_y >= {1'b0, cs_eff};
  assign ge_a = trial_a >= {1'b0, dc_eff};

  assign sq_rem_w = {sq_rem_q, sq_t_q[hcsg_pkg::SQ_T_W-1 -: 2]};
  assign sq_trial = {2'b00, sq_root_q, 2'b01};
  assign sq_ge    = sq_rem_w >= sq_trial;

  assign k_trial = {kr_q, kn_q[hcsg_pkg::M_W-1]};
  assign k_ge    = k_trial >= {1'b0, r_q};
  assign k_ceil  = kq_q + hcsg_pkg::M_W'(kr_q != 9'd0);
  assign k_clamp = (k_ceil > hcsg_pkg::M_W'(amount_q)) ? amount_q : k_ceil[8:0];

  assign in_x = !(xneg_q && (qx_q != 12'd0)) && (qx_q < 12'(nc));
  assign in_y = !(yneg_q && (qy_q != 12'd0)) && (qy_q < 12'(nr));

  assign hi_x = 10'(cx_q) + 10'(r_q);
  assign hi_y = 10'(cy_q) + 10'(r_q);

  assign di = 10'(i_q) - 10'(cx_q);
  assign dj = 10'(j_q) - 10'(cy_q);
  assign di_abs = di[9] ? 9'(-di) : di[8:0];
  assign dj_abs = dj[9] ? 9'(-dj) : dj[8:0];

  assign sat_sum = {1'b0, next_rdata} + (LEVEL_BITS+1)'(add_q);
  assign excess  = shown_wdata - LEVEL_BITS'(GREEN_KNEE_L);

  always_comb begin
    mem_addr    = '0;
    next_we     = 1'b0;
    shown_we    = 1'b0;
    next_wdata  = '0;
    shown_wdata = next_rdata;
    case (state_q)
      ST_INIT: begin
        mem_addr    = sweep_q;
        next_we     = 1'b1;
        shown_we    = 1'b1;
        shown_wdata = '0;
      end
      ST_CLEAR: begin
        mem_addr = sweep_q;
        next_we  = 1'b1;
      end
      ST_CHECK: begin
        mem_addr   = cell_addr(qx_q[IW-1:0], qy_q[IW-1:0]);
        next_we    = in_x && in_y && (amount_q != 9'd0);
        next_wdata = LEVEL_BITS'(amount_q);
      end
      ST_KDIV: begin
        mem_addr = cell_addr(i_q, j_q);
      end
      ST_RD: begin
        mem_addr   = cell_addr(i_q, j_q);
        next_we    = 1'b1;
        next_wdata = sat_sum[LEVEL_BITS] ? LEVEL_MAX : sat_sum[LEVEL_BITS-1:0];
      end
      ST_RADDR: begin
        mem_addr = cell_addr(IW'(col_q), IW'(row_q));
      end
      ST_RWAIT: begin
        mem_addr = cell_addr(IW'(col_q), IW'(row_q));
        shown_we = 1'b1;
      end
      default: begin
        mem_addr = '0;
      end
    endcase
  end

  hcsg_ram #(
    .WIDTH (LEVEL_BITS),
    .DEPTH (CELLS)
  ) u_next_ram (
    .clk_i   (clk_i),
    .we_i    (next_we),
    .addr_i  (mem_addr),
    .wdata_i (next_wdata),
    .rdata_o (next_rdata)
  );

  hcsg_ram #(
    .WIDTH (LEVEL_BITS),
    .DEPTH (CELLS)
  ) u_shown_ram (
    .clk_i   (clk_i),
    .we_i    (shown_we),
    .addr_i  (mem_addr),
    .wdata_i (shown_wdata),
    .rdata_o (shown_rdata)
  );

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_INIT:  if (sweep_q == LAST_ADDR) state_d = ST_IDLE;
      ST_IDLE: begin
        if (in_fire) begin
          case (kind_i)
            hcsg_pkg::KIND_CLEAR: state_d = ST_CLEAR;
            hcsg_pkg::KIND_SPLAT: state_d = ST_DIV;
            hcsg_pkg::KIND_READ: begin
              state_d = ((IW'(cell_col_i) < nc) && (IW'(cell_row_i) < nr)) ?
                        ST_RADDR : ST_DONE;
            end
            default: state_d = ST_DONE;
          endcase
        end
      end
      ST_CLEAR: if (sweep_q == LAST_ADDR) state_d = ST_DONE;
      ST_DIV:   if (cnt_q == 5'(hcsg_pkg::DIV_STEPS - 1)) state_d = ST_CHECK;
      ST_CHECK: begin
        state_d = (in_x && in_y && (amount_q != 9'd0) && (qa_q != 12'd0)) ?
                  ST_PREP : ST_DONE;
      end
      ST_PREP:  state_d = ST_D2;
      ST_D2:    state_d = ST_GATE;
      ST_GATE:  state_d = (18'(d2_q) > r2_q) ? ST_NEXT : ST_SQRT;
      ST_SQRT:  if (cnt_q == 5'(hcsg_pkg::SQ_STEPS)) state_d = ST_KDIV;
      ST_KDIV:  if (cnt_q == 5'(hcsg_pkg::K_STEPS)) state_d = ST_RD;
      ST_RD:    state_d = ST_NEXT;
      ST_NEXT:  state_d = ((j_q == y1_q) && (i_q == x1_q)) ? ST_DONE : ST_D2;
      ST_RADDR: state_d = ST_RWAIT;
      ST_RWAIT: state_d = ST_DONE;
      ST_DONE:  if (out_load) state_d = ST_IDLE;
      default:  state_d = ST_INIT;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_INIT;
      sweep_q     <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
      cell_size_q <= 5'd5;
      decay_q     <= 9'd50;
      cols_q      <= 7'd64;
      rows_q      <= 7'd64;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        case (cfg_index_i)
          hcsg_pkg::CFG_CELL_SIZE: cell_size_q <= cfg_wdata_i[4:0];
          hcsg_pkg::CFG_DECAY:     decay_q     <= cfg_wdata_i;
          hcsg_pkg::CFG_COLS:      cols_q      <= cfg_wdata_i[6:0];
          hcsg_pkg::CFG_ROWS:      rows_q      <= cfg_wdata_i[6:0];
          default:                 cols_q      <= cols_q;
        endcase
      end
      if ((state_q == ST_INIT) || (state_q == ST_CLEAR)) begin
        sweep_q <= (sweep_q == LAST_ADDR) ? '0 : sweep_q + 1'b1;
      end
      if (state_q != state_d) begin
        cnt_q <= '0;
      end else if ((state_q == ST_DIV) || (state_q == ST_SQRT) || (state_q == ST_KDIV)) begin
        cnt_q <= cnt_q + 5'd1;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_fire) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_level_q   <= res_level_q;
      out_red_q     <= res_red_q;
      out_green_q   <= res_green_q;
      out_blue_q    <= res_blue_q;
      out_changed_q <= res_changed_q;
      out_acc_q     <= res_acc_q;
    end
    case (state_q)
      ST_IDLE: begin
        amount_q      <= amount_i;
        col_q         <= cell_col_i;
        row_q         <= cell_row_i;
        xneg_q        <= x_pos_i[11];
        yneg_q        <= y_pos_i[11];
        nx_q          <= x_pos_i[11] ? 12'(-x_pos_i) : x_pos_i;
        ny_q          <= y_pos_i[11] ? 12'(-y_pos_i) : y_pos_i;
        na_q          <= {3'b000, amount_i};
        rx_q          <= '0;
        ry_q          <= '0;
        ra_q          <= '0;
        qx_q          <= '0;
        qy_q          <= '0;
        qa_q          <= '0;
        res_level_q   <= '0;
        res_red_q     <= '0;
        res_green_q   <= '0;
        res_blue_q    <= '0;
        res_changed_q <= 1'b0;
        res_acc_q     <= (kind_i == hcsg_pkg::KIND_CLEAR);
      end
      ST_DIV: begin
        nx_q <= {nx_q[10:0], 1'b0};
        ny_q <= {ny_q[10:0], 1'b0};
        na_q <= {na_q[10:0], 1'b0};
        rx_q <= ge_x ? 5'(trial_x - {1'b0, cs_eff}) : trial_x[4:0];
        ry_q <= ge_y ? 5'(trial_y - {1'b0, cs_eff}) : trial_y[4:0];
        ra_q <= ge_a ? 9'(trial_a - {1'b0, dc_eff}) : trial_a[8:0];
        qx_q <= {qx_q[10:0], ge_x};
        qy_q <= {qy_q[10:0], ge_y};
        qa_q <= {qa_q[10:0], ge_a};
      end
      ST_CHECK: begin
        res_acc_q <= in_x && in_y;
        cx_q      <= qx_q[IW-1:0];
        cy_q      <= qy_q[IW-1:0];
        r_q       <= qa_q[8:0];
      end
      ST_PREP: begin
        a2_q <= 18'(amount_q) * 18'(amount_q);
        r2_q <= 18'(r_q) * 18'(r_q);
        x0_q <= (cx_q >= r_q) ? cx_q - r_q : '0;
        y0_q <= (cy_q >= r_q) ? cy_q - r_q : '0;
        i_q  <= (cx_q >= r_q) ? cx_q - r_q : '0;
        j_q  <= (cy_q >= r_q) ? cy_q - r_q : '0;
        x1_q <= (hi_x > 10'(nc - 1'b1)) ? nc - 1'b1 : hi_x[IW-1:0];
        y1_q <= (hi_y > 10'(nr - 1'b1)) ? nr - 1'b1 : hi_y[IW-1:0];
      end
      ST_D2: begin
        d2_q <= hcsg_pkg::D2_W'(di_abs) * hcsg_pkg::D2_W'(di_abs) +
                hcsg_pkg::D2_W'(dj_abs) * hcsg_pkg::D2_W'(dj_abs);
      end
      ST_GATE: begin
        sq_t_q    <= hcsg_pkg::SQ_T_W'(a2_q) * hcsg_pkg::SQ_T_W'(d2_q);
        sq_rem_q  <= '0;
        sq_root_q <= '0;
      end
      ST_SQRT: begin
        if (cnt_q == 5'(hcsg_pkg::SQ_STEPS)) begin
          kn_q <= hcsg_pkg::M_W'(sq_root_q) + hcsg_pkg::M_W'(sq_rem_q != 20'd0);
          kq_q <= '0;
          kr_q <= '0;
        end else begin
          sq_t_q    <= {sq_t_q[hcsg_pkg::SQ_T_W-3:0], 2'b00};
          sq_rem_q  <= sq_ge ? 20'(sq_rem_w - sq_trial) : sq_rem_w[19:0];
          sq_root_q <= {sq_root_q[hcsg_pkg::ROOT_W-2:0], sq_ge};
        end
      end
      ST_KDIV: begin
        if (cnt_q == 5'(hcsg_pkg::K_STEPS)) begin
          add_q <= amount_q - k_clamp;
        end else begin
          kn_q <= {kn_q[hcsg_pkg::M_W-2:0], 1'b0};
          kr_q <= k_ge ? 9'(k_trial - {1'b0, r_q}) : k_trial[8:0];
          kq_q <= {kq_q[hcsg_pkg::M_W-2:0], k_ge};
        end
      end
      ST_NEXT: begin
        if (j_q == y1_q) begin
          j_q <= y0_q;
          i_q <= i_q + 1'b1;
        end else begin
          j_q <= j_q + 1'b1;
        end
      end
      ST_RWAIT: begin
        res_level_q   <= 16'(next_rdata);
        res_red_q     <= hcsg_pkg::COLOR_FULL;
        res_changed_q <= (next_rdata != shown_rdata);
        res_acc_q     <= 1'b1;
        if (next_rdata <= LEVEL_BITS'(GREEN_KNEE_L)) begin
          res_green_q <= hcsg_pkg::COLOR_FULL;
          res_blue_q  <= hcsg_pkg::GREEN_KNEE - 8'(next_rdata);
        end else begin
          res_green_q <= (excess >= LEVEL_BITS'(255)) ? 8'd0 :
                         hcsg_pkg::COLOR_FULL - 8'(excess);
          res_blue_q  <= 8'd0;
        end
      end
      default: begin
        add_q <= add_q;
      end
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign level_o     = out_level_q;
  assign red_o       = out_red_q;
  assign green_o     = out_green_q;
  assign blue_o      = out_blue_q;
  assign changed_o   = out_changed_q;
  assign accepted_o  = out_acc_q;

  a_shown_write_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    shown_we |-> (state_q == ST_INIT) || (state_q == ST_RWAIT))
    else $error("shown store written outside init or read");

  a_splat_no_decrease: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RD) |-> (next_wdata >= next_rdata))
    else $error("splat lowered a level");

  a_red_implies_acc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (out_red_q != 8'd0)) |-> out_acc_q)
    else $error("colored result without acceptance");

  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_INIT) |-> in_stall_o)
    else $error("item taken during clearing pass");

endmodule

// ===== design/hcsg_ram.sv =====
module hcsg_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 4096
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] addr_i,
  input  logic [WIDTH-1:0]                       wdata_i,
  output logic [WIDTH-1:0]                       rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    rdata_q <= mem[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule
